FILE: sv/lfpd_pkg.sv
`timescale 1ns / 1ps

package lfpd_pkg;

  // default structure of the sensor bar and the error format
  localparam int SENSOR_COUNT_DEF = 8;
  localparam int FRAC_BITS_DEF    = 8;

  // fixed field and state widths
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 8;
  localparam int DUTY_W     = 8;
  localparam int HOLD_W     = 12;
  localparam int ERR_W      = 12;
  localparam int INTG_W     = 16;
  localparam int JCNT_W     = 5;
  localparam int TGT_W      = 4;
  localparam int CORR_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // shared multiply-accumulate widths
  localparam int MAC_A_W = 17;
  localparam int MAC_B_W = 17;
  localparam int MAC_W   = MAC_A_W + MAC_B_W;

  // saturation bounds
  localparam int ERR_MAX  = 2047;
  localparam int ERR_MIN  = -2048;
  localparam int INTG_MAX = 32767;
  localparam int INTG_MIN = -32768;
  localparam int CORR_MAX = 511;
  localparam logic [JCNT_W-1:0] JCNT_MAX = 5'd31;

  // register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd5632;
  localparam logic [GAIN_W-1:0] INTG_GAIN_RST  = 16'd154;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd768;
  localparam logic [DUTY_W-1:0] BASE_RST       = 8'd205;
  localparam logic [DUTY_W-1:0] SEARCH_RST     = 8'd205;
  localparam logic [DUTY_W-1:0] LIMIT_RST      = 8'd205;

  // hold times in ms
  localparam logic [HOLD_W-1:0] HOLD_NONE     = 12'd0;
  localparam logic [HOLD_W-1:0] HOLD_DONE     = 12'd10;
  localparam logic [HOLD_W-1:0] HOLD_STRAIGHT = 12'd1000;
  localparam logic [HOLD_W-1:0] HOLD_TURN     = 12'd2600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_INTG_GAIN  = 3'd1,
    CFG_DERIV_GAIN = 3'd2,
    CFG_BASE_SPEED = 3'd3,
    CFG_SRCH_SPEED = 3'd4,
    CFG_PWM_LIMIT  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    ACT_START  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ERR,
    ST_INTG,
    ST_PROP,
    ST_DER,
    ST_INT,
    ST_CORR,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctrl_t;

  typedef struct packed {
    logic              left_drive;
    logic              right_drive;
    logic [HOLD_W-1:0] hold_ms;
    logic              trip_done;
  } result_t;

  // clamp a wide error to the signed error format
  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [31:0] v);
    logic signed [ERR_W-1:0] r;
    if (v > ERR_MAX) r = ERR_W'(ERR_MAX);
    else if (v < ERR_MIN) r = ERR_W'(ERR_MIN);
    else r = ERR_W'(v);
    return r;
  endfunction

  // clamp the shifted accumulator to the integral format
  function automatic logic signed [INTG_W-1:0] sat_intg(input logic signed [MAC_W-1:0] v);
    logic signed [INTG_W-1:0] r;
    if (v > MAC_W'(INTG_MAX)) r = INTG_W'(INTG_MAX);
    else if (v < MAC_W'(INTG_MIN)) r = INTG_W'(INTG_MIN);
    else r = INTG_W'(v);
    return r;
  endfunction

  // clamp the shifted accumulator to the symmetric correction range
  function automatic logic signed [CORR_W-1:0] sat_corr(input logic signed [MAC_W-1:0] v);
    logic signed [CORR_W-1:0] r;
    if (v > MAC_W'(CORR_MAX)) r = CORR_W'(CORR_MAX);
    else if (v < -MAC_W'(CORR_MAX)) r = -CORR_W'(CORR_MAX);
    else r = CORR_W'(v);
    return r;
  endfunction

endpackage

FILE: sv/lfpd_div.sv
`timescale 1ns / 1ps

module lfpd_div import lfpd_pkg::*; #(
  parameter int DVD_W = 14,
  parameter int DVS_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] quot_q, quot_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_shift;
  logic [DVS_W+1:0] diff;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_shift = {rem_q, quot_q[DVD_W-1]};
    diff      = {1'b0, rem_shift} - {2'b00, dvs_q};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    quot_d    = quot_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (diff[DVS_W+1]) begin
        rem_d  = rem_shift[DVS_W-1:0];
        quot_d = {quot_q[DVD_W-2:0], 1'b0};
      end else begin
        rem_d  = diff[DVS_W-1:0];
        quot_d = {quot_q[DVD_W-2:0], 1'b1};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: sv/lfpd_mac.sv
`timescale 1ns / 1ps

module lfpd_mac import lfpd_pkg::*; (
  input  logic                      clk_i,
  input  mac_ctrl_t                 ctrl_i,
  input  logic signed [MAC_A_W-1:0] a_i,
  input  logic signed [MAC_B_W-1:0] b_i,
  output logic signed [MAC_W-1:0]   acc_o
);

  logic signed [MAC_W-1:0] acc_q, acc_d;
  logic signed [MAC_W-1:0] prod;

  // signed multiply, optionally added to the running sum
  always_comb begin
    prod  = a_i * b_i;
    acc_d = acc_q;
    if (ctrl_i.en) begin
      if (ctrl_i.clr) acc_d = prod;
      else acc_d = acc_q + prod;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

FILE: sv/line_follow_pid_junction_drive.sv
`timescale 1ns / 1ps
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: sensors, table; tuser: action
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: drives, duties, hold; tlast: trip done
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// a start, an ignored sample, a lost line or a junction goes from idle to the emit
// step; a steering sample first passes the bit-serial divider for the line position
// and four passes through the shared multiply-accumulate. one request is in work at
// a time; s_axis_tready is low from the request until its result is loaded into the
// output register. reset is asynchronous active low and restores gains, speeds and
// the trip state but the result payload. a result waiting on m_axis_tready does not
// stop the next request, but holds the next result, the sequencer and s_axis_tready.

module line_follow_pid_junction_drive import lfpd_pkg::*; #(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // [7:0] line_sensors, [11:8] table_number, [15:12] zero
  input  logic [15:0]           s_axis_tdata,
  // [0] action
  input  logic [0:0]            s_axis_tuser,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [0] left_drive, [1] right_drive, [9:2] left_duty, [17:10] right_duty,
  // [29:18] hold_ms, [31:30] zero
  output logic [31:0]           m_axis_tdata,
  output logic                  m_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SUM_W = $clog2(SENSOR_COUNT * (SENSOR_COUNT + 1) / 2 + 1);
  localparam int LIT_W = $clog2(SENSOR_COUNT + 1);
  localparam int DVD_W = SUM_W + FRAC_BITS;
  localparam int CENTER = ((SENSOR_COUNT + 1) * (1 << FRAC_BITS)) / 2;

  // configuration registers
  logic [GAIN_W-1:0] prop_gain_q, intg_gain_q, deriv_gain_q;
  logic [DUTY_W-1:0] base_speed_q, search_speed_q, pwm_limit_q;

  // trip state
  seq_state_e               state_q, state_d;
  logic signed [ERR_W-1:0]  line_error_q, line_error_d;
  logic signed [ERR_W-1:0]  prev_error_q, prev_error_d;
  logic signed [INTG_W-1:0] integral_q, integral_d;
  logic [JCNT_W-1:0]        jcnt_q, jcnt_d;
  logic [TGT_W-1:0]         target_q, target_d;
  logic                     last_left_q, last_left_d;
  logic                     running_q, running_d;
  logic [DUTY_W-1:0]        held_l_q, held_l_d, held_r_q, held_r_d;
  result_t                  res_q, res_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;
  logic        out_last_q, out_last_d;

  // request decode
  logic                    accept;
  action_e                 action;
  logic [TGT_W-1:0]        table_num;
  logic [SENSOR_COUNT+7:0] sens_ext;
  logic [SENSOR_COUNT-1:0] sens;
  logic [SUM_W-1:0]        sum_w;
  logic [LIT_W-1:0]        lit;
  logic                    new_left;
  logic [JCNT_W-1:0]       jcnt_next;

  // shared units
  mac_ctrl_t                mac_ctrl;
  logic signed [MAC_A_W-1:0] mac_a;
  logic signed [MAC_B_W-1:0] mac_b;
  logic signed [MAC_W-1:0]   mac_acc;
  logic                      div_start;
  logic                      div_done;
  logic [DVD_W-1:0]          div_quot;

  // final steering arithmetic
  logic signed [31:0]         err_wide;
  logic signed [CORR_W-1:0]   corr;
  logic signed [DUTY_W+2:0]   left_s, right_s, limit_s;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign action    = action_e'(s_axis_tuser[0]);
  assign table_num = s_axis_tdata[11:8];
  assign sens_ext  = {{SENSOR_COUNT{1'b0}}, s_axis_tdata[7:0]};
  assign sens      = sens_ext[SENSOR_COUNT-1:0];

  // lit count and position weights, bit 0 weighs the most
  always_comb begin
    lit   = '0;
    sum_w = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (sens[i]) begin
        lit   = lit + LIT_W'(1);
        sum_w = sum_w + SUM_W'(SENSOR_COUNT - i);
      end
    end
  end

  assign new_left  = sens[SENSOR_COUNT-1] ? 1'b1 : (sens[0] ? 1'b0 : last_left_q);
  assign jcnt_next = (jcnt_q < JCNT_MAX) ? jcnt_q + JCNT_W'(1) : jcnt_q;

  assign err_wide = 32'(signed'({1'b0, div_quot})) - CENTER;
  assign corr     = sat_corr(mac_acc >>> (FRAC_BITS + GAIN_FRAC));
  assign left_s   = signed'({3'b000, base_speed_q}) + (DUTY_W + 3)'(corr);
  assign right_s  = signed'({3'b000, base_speed_q}) - (DUTY_W + 3)'(corr);
  assign limit_s  = signed'({3'b000, pwm_limit_q});

  lfpd_div #(
    .DVD_W(DVD_W),
    .DVS_W(LIT_W)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start),
    .dividend_i({sum_w, {FRAC_BITS{1'b0}}}),
    .divisor_i (lit),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  lfpd_mac u_mac (
    .clk_i,
    .ctrl_i(mac_ctrl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (mac_acc)
  );

  // sequencer: next state, datapath steps and result loading
  always_comb begin
    state_d      = state_q;
    line_error_d = line_error_q;
    prev_error_d = prev_error_q;
    integral_d   = integral_q;
    jcnt_d       = jcnt_q;
    target_d     = target_q;
    last_left_d  = last_left_q;
    running_d    = running_q;
    held_l_d     = held_l_q;
    held_r_d     = held_r_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    div_start    = 1'b0;
    mac_ctrl     = '0;
    mac_a        = '0;
    mac_b        = '0;
    s_axis_tready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d   = '0;
          state_d = ST_EMIT;
          if (action == ACT_START) begin
            jcnt_d    = '0;
            target_d  = table_num;
            running_d = 1'b1;
          end else if (running_q) begin
            last_left_d  = new_left;
            prev_error_d = line_error_q;
            if (lit == '0) begin
              // line lost: spin toward the side seen last
              held_l_d          = search_speed_q;
              held_r_d          = search_speed_q;
              res_d.left_drive  = !new_left;
              res_d.right_drive = new_left;
            end else if (lit == LIT_W'(SENSOR_COUNT)) begin
              // junction: count it and pick the move
              line_error_d = '0;
              jcnt_d       = jcnt_next;
              if (jcnt_next > {1'b0, target_q}) begin
                running_d       = 1'b0;
                res_d.hold_ms   = HOLD_DONE;
                res_d.trip_done = 1'b1;
              end else if (jcnt_next == {1'b0, target_q}) begin
                res_d.left_drive = 1'b1;
                res_d.hold_ms    = HOLD_TURN;
              end else begin
                res_d.left_drive  = 1'b1;
                res_d.right_drive = 1'b1;
                res_d.hold_ms     = HOLD_STRAIGHT;
              end
            end else begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_ERR;
      end
      ST_ERR: begin
        line_error_d = sat_err(err_wide);
        state_d      = ST_INTG;
      end
      ST_INTG: begin
        // leaky integral: (I + e) * Ki
        mac_ctrl = '{en: 1'b1, clr: 1'b1};
        mac_a    = MAC_A_W'(integral_q) + MAC_A_W'(line_error_q);
        mac_b    = signed'({1'b0, intg_gain_q});
        state_d  = ST_PROP;
      end
      ST_PROP: begin
        integral_d = sat_intg(mac_acc >>> GAIN_FRAC);
        mac_ctrl   = '{en: 1'b1, clr: 1'b1};
        mac_a      = MAC_A_W'(line_error_q);
        mac_b      = signed'({1'b0, prop_gain_q});
        state_d    = ST_DER;
      end
      ST_DER: begin
        mac_ctrl = '{en: 1'b1, clr: 1'b0};
        mac_a    = MAC_A_W'(line_error_q) - MAC_A_W'(prev_error_q);
        mac_b    = signed'({1'b0, deriv_gain_q});
        state_d  = ST_INT;
      end
      ST_INT: begin
        // integral term enters at gain scale
        mac_ctrl = '{en: 1'b1, clr: 1'b0};
        mac_a    = MAC_A_W'(integral_q);
        mac_b    = MAC_B_W'(1 << GAIN_FRAC);
        state_d  = ST_CORR;
      end
      ST_CORR: begin
        if (left_s < 0) held_l_d = '0;
        else if (left_s > limit_s) held_l_d = pwm_limit_q;
        else held_l_d = left_s[DUTY_W-1:0];
        if (right_s < 0) held_r_d = '0;
        else if (right_s > limit_s) held_r_d = pwm_limit_q;
        else held_r_d = right_s[DUTY_W-1:0];
        res_d.left_drive  = 1'b1;
        res_d.right_drive = 1'b1;
        state_d           = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {2'b00, res_q.hold_ms, held_r_q, held_l_q,
                         res_q.right_drive, res_q.left_drive};
          out_last_d  = res_q.trip_done;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer and trip state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      line_error_q <= '0;
      prev_error_q <= '0;
      integral_q   <= '0;
      jcnt_q       <= '0;
      target_q     <= '0;
      last_left_q  <= 1'b0;
      running_q    <= 1'b0;
      held_l_q     <= '0;
      held_r_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      line_error_q <= line_error_d;
      prev_error_q <= prev_error_d;
      integral_q   <= integral_d;
      jcnt_q       <= jcnt_d;
      target_q     <= target_d;
      last_left_q  <= last_left_d;
      running_q    <= running_d;
      held_l_q     <= held_l_d;
      held_r_q     <= held_r_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= PROP_GAIN_RST;
      intg_gain_q    <= INTG_GAIN_RST;
      deriv_gain_q   <= DERIV_GAIN_RST;
      base_speed_q   <= BASE_RST;
      search_speed_q <= SEARCH_RST;
      pwm_limit_q    <= LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PROP_GAIN:  prop_gain_q    <= cfg_data_i;
        CFG_INTG_GAIN:  intg_gain_q    <= cfg_data_i;
        CFG_DERIV_GAIN: deriv_gain_q   <= cfg_data_i;
        CFG_BASE_SPEED: base_speed_q   <= cfg_data_i[DUTY_W-1:0];
        CFG_SRCH_SPEED: search_speed_q <= cfg_data_i[DUTY_W-1:0];
        CFG_PWM_LIMIT:  pwm_limit_q    <= cfg_data_i[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // a taken request always leaves idle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("request accepted without leaving idle");

  // steering duties stay inside the clamp
  a_duty_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CORR) |=> (held_l_q <= pwm_limit_q) && (held_r_q <= pwm_limit_q))
    else $error("steering duty above pwm limit");

  // the divider only finishes while the sequencer waits on it
  a_div_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside its step");

  // a start request arms the trip
  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action == ACT_START) |=> running_q && (jcnt_q == '0))
    else $error("start request did not arm the trip");

  // a free output slot takes the result and frees the input
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && (!out_valid_q || m_axis_tready)) |=>
      out_valid_q && s_axis_tready)
    else $error("result not loaded into free output slot");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lfpd_pkg::*;

  localparam int CLK_HALF   = 6;
  localparam int SETTLE_CYC = 30;
  localparam int GAP_CAP    = 40;
  localparam int CENTER_Q   = (SENSOR_COUNT_DEF + 1) * (1 << FRAC_BITS_DEF) / 2;

  // one drive command as it leaves the block
  typedef struct packed {
    logic              left_fwd;
    logic              right_fwd;
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic [HOLD_W-1:0] hold;
    logic              done;
  } drive_cmd_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic [15:0]           s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // random idling, in percent
  int gap_pct   = 0;
  int stall_pct = 0;

  int fail_count = 0;
  int result_num = 0;

  // drive commands still owed by the block, oldest first
  drive_cmd_t pending_cmds[$];

  // register copy
  logic [GAIN_W-1:0] kp          = PROP_GAIN_RST;
  logic [GAIN_W-1:0] ki          = INTG_GAIN_RST;
  logic [GAIN_W-1:0] kd          = DERIV_GAIN_RST;
  logic [DUTY_W-1:0] base_duty   = BASE_RST;
  logic [DUTY_W-1:0] search_duty = SEARCH_RST;
  logic [DUTY_W-1:0] limit_duty  = LIMIT_RST;

  // trip and controller state
  int                err_now   = 0;
  int                err_last  = 0;
  int                intg_acc  = 0;
  int                junctions = 0;
  int                target_jn = 0;
  bit                side_left = 1'b0;
  bit                trip_on   = 1'b0;
  logic [DUTY_W-1:0] duty_l    = '0;
  logic [DUTY_W-1:0] duty_r    = '0;

  line_follow_pid_junction_drive u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // next drive command for one request, advancing the trip state
  function automatic drive_cmd_t steer_drive(input action_e act, input logic [7:0] sens,
                                             input logic [3:0] tbl);
    drive_cmd_t cmd;
    int         lit;
    int         wsum;
    int         i;
    longint     q;
    longint     acc;
    longint     corr;
    cmd.left_fwd  = 1'b0;
    cmd.right_fwd = 1'b0;
    cmd.hold      = HOLD_NONE;
    cmd.done      = 1'b0;
    if (act == ACT_START) begin
      junctions = 0;
      target_jn = int'(tbl);
      trip_on   = 1'b1;
    end else if (trip_on) begin
      lit  = 0;
      wsum = 0;
      for (i = 0; i < SENSOR_COUNT_DEF; i++) begin
        if (sens[i]) begin
          lit++;
          wsum += SENSOR_COUNT_DEF - i;
        end
      end
      if (sens[0]) side_left = 1'b0;
      if (sens[SENSOR_COUNT_DEF-1]) side_left = 1'b1;
      err_last = err_now;
      if (lit == 0) begin
        // line lost: spin toward the last side seen
        duty_l        = search_duty;
        duty_r        = search_duty;
        cmd.left_fwd  = !side_left;
        cmd.right_fwd = side_left;
      end else begin
        q       = (longint'(wsum) << FRAC_BITS_DEF) / lit;
        err_now = int'(clamp(q - CENTER_Q, ERR_MIN, ERR_MAX));
        if (lit == SENSOR_COUNT_DEF) begin
          // junction crossed
          if (junctions < 31) junctions++;
          if (junctions > target_jn) begin
            trip_on  = 1'b0;
            cmd.hold = HOLD_DONE;
            cmd.done = 1'b1;
          end else if (junctions == target_jn) begin
            cmd.left_fwd = 1'b1;
            cmd.hold     = HOLD_TURN;
          end else begin
            cmd.left_fwd  = 1'b1;
            cmd.right_fwd = 1'b1;
            cmd.hold      = HOLD_STRAIGHT;
          end
        end else begin
          // pid steering with leaky integral
          acc      = ((longint'(intg_acc) + longint'(err_now)) * longint'(ki)) >>> GAIN_FRAC;
          intg_acc = int'(clamp(acc, INTG_MIN, INTG_MAX));
          corr     = longint'(err_now) * longint'(kp) + longint'(intg_acc) * 256
                   + (longint'(err_now) - longint'(err_last)) * longint'(kd);
          corr     = clamp(corr >>> (FRAC_BITS_DEF + GAIN_FRAC), -CORR_MAX, CORR_MAX);
          duty_l   = DUTY_W'(clamp(longint'(base_duty) + corr, 0, longint'(limit_duty)));
          duty_r   = DUTY_W'(clamp(longint'(base_duty) - corr, 0, longint'(limit_duty)));
          cmd.left_fwd  = 1'b1;
          cmd.right_fwd = 1'b1;
        end
      end
    end
    cmd.left_duty  = duty_l;
    cmd.right_duty = duty_r;
    return cmd;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("result %0d: %s got %0d expected %0d", result_num, what, got_v, want_v);
    fail_count++;
  endtask

  // result side: random stall and field checks
  always @(posedge clk_i) begin : result_check
    drive_cmd_t got;
    drive_cmd_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.left_fwd   = m_axis_tdata[0];
      got.right_fwd  = m_axis_tdata[1];
      got.left_duty  = m_axis_tdata[9:2];
      got.right_duty = m_axis_tdata[17:10];
      got.hold       = m_axis_tdata[29:18];
      got.done       = m_axis_tlast;
      if (pending_cmds.size() == 0) begin
        report_mismatch("unexpected result, data", int'(m_axis_tdata), 0);
      end else begin
        want = pending_cmds.pop_front();
        if (got.left_fwd != want.left_fwd)
          report_mismatch("left_drive", got.left_fwd, want.left_fwd);
        if (got.right_fwd != want.right_fwd)
          report_mismatch("right_drive", got.right_fwd, want.right_fwd);
        if (got.left_duty != want.left_duty)
          report_mismatch("left_duty", got.left_duty, want.left_duty);
        if (got.right_duty != want.right_duty)
          report_mismatch("right_duty", got.right_duty, want.right_duty);
        if (got.hold != want.hold)
          report_mismatch("hold_ms", got.hold, want.hold);
        if (got.done != want.done)
          report_mismatch("trip_done", got.done, want.done);
      end
      result_num++;
    end
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // one request on s_axis, predicted when it is taken
  task automatic send_item(input action_e act, input logic [7:0] sens, input logic [3:0] tbl);
    int gap;
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {4'h0, tbl, sens};
    s_axis_tuser  <= act;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_cmds.push_back(steer_drive(act, sens, tbl));
  endtask

  // stop sending and let the block drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PROP_GAIN:  kp          = val;
      CFG_INTG_GAIN:  ki          = val;
      CFG_DERIV_GAIN: kd          = val;
      CFG_BASE_SPEED: base_duty   = val[DUTY_W-1:0];
      CFG_SRCH_SPEED: search_duty = val[DUTY_W-1:0];
      CFG_PWM_LIMIT:  limit_duty  = val[DUTY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] p, input logic [15:0] i, input logic [15:0] d,
                              input logic [7:0] b, input logic [7:0] s, input logic [7:0] l);
    write_reg(CFG_PROP_GAIN, p);
    write_reg(CFG_INTG_GAIN, i);
    write_reg(CFG_DERIV_GAIN, d);
    write_reg(CFG_BASE_SPEED, {8'h00, b});
    write_reg(CFG_SRCH_SPEED, {8'h00, s});
    write_reg(CFG_PWM_LIMIT, {8'h00, l});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1:       begin gap_pct = 73; stall_pct = 0;  end
      2:       begin gap_pct = 0;  stall_pct = 73; end
      3:       begin gap_pct = 36; stall_pct = 36; end
      default: begin gap_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // a plausible line under the bar: a narrow stripe or any partial pattern
  function automatic logic [7:0] line_pattern();
    int w;
    int p;
    if ($urandom_range(99) < 60) begin
      w = $urandom_range(1, 3);
      p = $urandom_range(0, SENSOR_COUNT_DEF - w);
      return 8'(((1 << w) - 1) << p);
    end
    return 8'($urandom_range(1, 254));
  endfunction

  // samples with no trip running are ignored
  task automatic test_ignored_before_start();
    send_item(ACT_SAMPLE, 8'hFF, 4'h0);
    send_item(ACT_SAMPLE, 8'h18, 4'hF);
  endtask

  // line positions from centered to both edges
  task automatic test_steering();
    send_item(ACT_START, 8'hFF, 4'd3);
    send_item(ACT_SAMPLE, 8'h18, 4'h0);
    send_item(ACT_SAMPLE, 8'h01, 4'h0);
    send_item(ACT_SAMPLE, 8'h80, 4'h0);
    send_item(ACT_SAMPLE, 8'h81, 4'h0);
    send_item(ACT_SAMPLE, 8'h7E, 4'h0);
    send_item(ACT_SAMPLE, 8'hAA, 4'h0);
    send_item(ACT_SAMPLE, 8'h55, 4'h0);
    send_item(ACT_SAMPLE, 8'h0F, 4'h0);
    send_item(ACT_SAMPLE, 8'hF0, 4'h0);
  endtask

  // search spin toward the left, then toward the right
  task automatic test_line_lost();
    send_item(ACT_SAMPLE, 8'h80, 4'h0);
    send_item(ACT_SAMPLE, 8'h00, 4'h0);
    send_item(ACT_SAMPLE, 8'h01, 4'h0);
    send_item(ACT_SAMPLE, 8'h00, 4'h0);
  endtask

  // straight, turn at the target, stop past it; target zero and fifteen
  task automatic test_junctions();
    send_item(ACT_SAMPLE, 8'hFF, 4'h0);
    send_item(ACT_SAMPLE, 8'hFF, 4'h0);
    send_item(ACT_SAMPLE, 8'hFF, 4'h0);
    send_item(ACT_SAMPLE, 8'hFF, 4'h0);
    send_item(ACT_SAMPLE, 8'h3C, 4'h0);
    send_item(ACT_START, 8'h00, 4'd0);
    send_item(ACT_SAMPLE, 8'hFF, 4'h0);
    send_item(ACT_START, 8'hFF, 4'd15);
  endtask

  // register settings per phase, extremes among them
  task automatic test_gain_setting(input int ph);
    case (ph)
      0: program_regs(16'd5632, 16'd154, 16'd768, 8'd205, 8'd205, 8'd205);
      1: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 8'd255);
      2: program_regs(16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'd0);
      // no leak: the integral runs into saturation
      3: program_regs(16'd10240, 16'd256, 16'd0, 8'd128, 8'd60, 8'd255);
      // base above the limit
      4: program_regs(16'd5632, 16'd154, 16'd768, 8'd255, 8'd1, 8'd20);
      default: program_regs(16'($urandom), 16'($urandom_range(0, 400)), 16'($urandom),
                            8'($urandom), 8'($urandom), 8'($urandom));
    endcase
  endtask

  // trips with random content, plus stray starts and ignored samples
  task automatic test_random_trips(input int n_items);
    int          taken;
    int          roll;
    logic [7:0]  sens;
    logic [3:0]  tbl;
    action_e     act;
    taken = 0;
    while (taken < n_items) begin
      roll = $urandom_range(99);
      tbl  = ($urandom_range(99) < 75) ? 4'($urandom_range(0, 4)) : 4'($urandom);
      sens = 8'($urandom);
      act  = ACT_SAMPLE;
      if (!trip_on) begin
        if (roll < 85) act = ACT_START;
      end else if (roll < 3) begin
        act = ACT_START;
      end else if (roll < 15) begin
        sens = 8'hFF;
      end else if (roll < 23) begin
        sens = 8'h00;
      end else begin
        sens = line_pattern();
      end
      if (act == ACT_START || trip_on) taken++;
      send_item(act, sens, tbl);
    end
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ignored_before_start();
    test_steering();
    test_line_lost();
    test_junctions();
    settle();
    for (int ph = 0; ph < 8; ph++) begin
      set_idling(ph % 4);
      test_gain_setting(ph);
      test_random_trips(190);
    end
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: line_follow_pid_junction_drive.f
sv/lfpd_pkg.sv
sv/lfpd_div.sv
sv/lfpd_mac.sv
sv/line_follow_pid_junction_drive.sv
dv/tb_top.sv
